### sv/sfj_pkg.sv
// ----------------------------------------------------------------------------
// Spring force and Jacobian package
// Shared widths, result group codes and the output saturation function.
// ----------------------------------------------------------------------------
`default_nettype none

package sfj_pkg;

  // Coordinate, difference, parameter, squared-length, length and value widths.
  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int PARM_W  = 31;
  localparam int SQ_W    = 66;
  localparam int LEN_W   = 33;
  localparam int VAL_W   = 32;

  // Latency of one pipelined multiplier.
  localparam int MUL_LAT = 5;

  // Width that every intermediate result is widened to before saturation.
  localparam int SAT_W = 130;

  // Stream word widths.
  localparam int S_TDATA_W = 256;
  localparam int M_TDATA_W = 104;

  // Result groups, in the order they leave the block.
  localparam int N_GROUPS = 6;
  localparam logic [2:0] GRP_FORCE  = 3'd0;
  localparam logic [2:0] GRP_DIAG   = 3'd1;
  localparam logic [2:0] GRP_OFF    = 3'd2;
  localparam logic [2:0] GRP_DSTIFF = 3'd3;
  localparam logic [2:0] GRP_DREST  = 3'd4;
  localparam logic [2:0] GRP_ENERGY = 3'd5;

  // Optionally negate, then clamp to the signed 32-bit range; zero forces 0.
  function automatic logic [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v,
                                             input logic neg, input logic zero);
    logic signed [SAT_W-1:0] t;
    logic [VAL_W-1:0] r;
    t = neg ? -v : v;
    if ((&t[SAT_W-1:VAL_W-1]) || !(|t[SAT_W-1:VAL_W-1])) begin
      r = t[VAL_W-1:0];
    end else begin
      r = t[SAT_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    if (zero) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/spring_force_jacobian_top.sv
// ----------------------------------------------------------------------------
// Spring force and Jacobian
// One spring in, six result words out: force, Jacobian diagonal, Jacobian
// off-diagonal, force derivatives by stiffness and by rest length, energy.
// ----------------------------------------------------------------------------
// The block takes one spring word per cycle whenever the pipeline has room
// and delivers six result words per spring, group 0 to 5, the energy word
// marked with tlast; sustained throughput is therefore set by the single
// result channel, which sends the six words of each spring in turn. On the
// way from acceptance to the result bank a spring passes the input stage,
// one round of five-stage multipliers for the squares, a 33-stage square
// root, a (33 + FRAC_BITS) stage divider and three rounds of multipliers
// after it. A zero-length spring still yields six words, all zero, with
// tuser set.
`default_nettype none

module spring_force_jacobian_top import sfj_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, stiffness,
  // rest_length, zero fill
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // group, value_a, value_b, value_c, zero fill
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast,
  // degenerate
  output logic                 m_tuser
);

  localparam int F    = FRAC_BITS;
  localparam int LM   = MUL_LAT;
  localparam int NW   = LEN_W + F;
  localparam int WW   = F + 2;
  localparam int SW   = NW + 1;
  localparam int EXW  = LEN_W + 1;
  localparam int SEW  = 32 + EXW - F + 1;
  localparam int WWW  = WW + WW - F + 1;
  localparam int DKW  = EXW + WW - F + 1;
  localparam int DRW  = 32 + WW - F + 1;
  localparam int EEW  = EXW + EXW - F + 1;
  localparam int FW   = SEW + WW - F + 1;
  localparam int RWW  = 32 + WWW - F + 1;
  localparam int ENW  = 32 + EEW - F + 1;
  localparam int XW   = RWW + 1;
  localparam int DGW  = SW + XW - F + 1;
  localparam int OFW  = SW + RWW - F + 1;
  localparam int SQPW = 2 * DIFF_W + 1;
  localparam int TL   = 2 + LM + LEN_W;
  localparam int TW   = TL + NW;
  localparam int TE   = TW + 3 * LM + 1;

  localparam int D0W = 2 * PARM_W;
  localparam int D1W = 3 * DIFF_W + 3;
  localparam int D2W = 2 * PARM_W + EXW + 4;
  localparam int DAW = 2 * PARM_W + EXW + SW + 1 + 3 * WW;
  localparam int DBW = EXW + SW + 1 + 3 * DKW + 3 * DRW;
  localparam int DCW = 3 * FW + ENW + 3 * DKW + 3 * DRW + 1;

  // Pipeline control.
  logic [TE:1] vld;
  logic en, free, load;
  logic busy;
  logic [2:0] cnt;

  assign free     = !busy || (m_tready && (cnt == GRP_ENERGY));
  assign load     = vld[TE] && free;
  assign en       = !vld[TE] || free;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TE-1:1], s_tvalid};
    end
  end

  // Input stage: endpoint differences.
  logic signed [DIFF_W-1:0] d_r [3];
  logic [PARM_W-1:0] stiff_r, rest_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= {s_tdata[32*i+31], s_tdata[32*i +: COORD_W]}
                - {s_tdata[32*i+127], s_tdata[32*i+96 +: COORD_W]};
      end
      stiff_r <= s_tdata[192 +: PARM_W];
      rest_r  <= s_tdata[223 +: PARM_W];
    end
  end

  // Magnitudes and signs of the differences for the dividers.
  logic [DIFF_W-1:0] md_r [3];
  logic [2:0] dneg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        md_r[i]   <= d_r[i][DIFF_W-1] ? DIFF_W'(-d_r[i]) : DIFF_W'(d_r[i]);
        dneg_r[i] <= d_r[i][DIFF_W-1];
      end
    end
  end

  // Squared length.
  logic signed [SQPW-1:0] sq_p [3];
  logic [SQ_W-1:0] sum_r;
  logic [LEN_W-1:0] len;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_sq
      sfj_mul #(.WA(DIFF_W), .WB(DIFF_W), .SHIFT(0)) u_sq (
        .clk(clk), .en(en), .a(d_r[g]), .b(d_r[g]), .p(sq_p[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sq_p[0][SQ_W-1:0] + sq_p[1][SQ_W-1:0] + sq_p[2][SQ_W-1:0];
    end
  end

  sfj_sqrt u_sqrt (.clk(clk), .en(en), .rad(sum_r), .root(len));

  // Side data carried to the square root output.
  logic [D0W-1:0] d0_q;
  logic [D1W-1:0] d1_q;
  logic [PARM_W-1:0] stiff_l, rest_l;
  logic [DIFF_W-1:0] md_l [3];
  logic [2:0] dneg_l;

  sfj_dly #(.W(D0W), .DEPTH(TL-1)) u_d0 (
    .clk(clk), .en(en), .d({stiff_r, rest_r}), .q(d0_q)
  );
  sfj_dly #(.W(D1W), .DEPTH(TL-2)) u_d1 (
    .clk(clk), .en(en), .d({md_r[0], md_r[1], md_r[2], dneg_r}), .q(d1_q)
  );
  assign {stiff_l, rest_l} = d0_q;
  assign {md_l[0], md_l[1], md_l[2], dneg_l} = d1_q;

  // Extension, degenerate flag and the four divisions by the length.
  logic signed [EXW-1:0] ext_l;
  logic degen_l;
  logic [NW-1:0] qw [3];
  logic [NW-1:0] qs;

  assign ext_l   = {1'b0, len} - EXW'(rest_l);
  assign degen_l = (len == '0);

  generate
    for (g = 0; g < 3; g++) begin : g_wdiv
      sfj_div #(.NW(NW), .DW(LEN_W)) u_div (
        .clk(clk), .en(en), .num({md_l[g], {F{1'b0}}}), .den(len), .quo(qw[g])
      );
    end
  endgenerate

  sfj_div #(.NW(NW), .DW(LEN_W)) u_sdiv (
    .clk(clk), .en(en), .num(NW'({stiff_l, {F{1'b0}}})), .den(len), .quo(qs)
  );

  logic [D2W-1:0] d2_q;
  logic [PARM_W-1:0] stiff_w, rest_w;
  logic signed [EXW-1:0] ext_w;
  logic degen_w;
  logic [2:0] dneg_w;

  sfj_dly #(.W(D2W), .DEPTH(NW)) u_d2 (
    .clk(clk), .en(en), .d({stiff_l, rest_l, ext_l, degen_l, dneg_l}), .q(d2_q)
  );
  assign {stiff_w, rest_w, ext_w, degen_w, dneg_w} = d2_q;

  // Unit vector components and stiffness over length.
  logic signed [WW-1:0] w_w [3];
  logic signed [SW-1:0] s_w;
  logic signed [WW-1:0] wm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wm[i]  = {1'b0, qw[i][F:0]};
      w_w[i] = dneg_w[i] ? -wm[i] : wm[i];
    end
  end
  assign s_w = {1'b0, qs};

  // First multiply round.
  logic signed [SEW-1:0] se_p;
  logic signed [WWW-1:0] ww_d [3];
  logic signed [WWW-1:0] ww_o [3];
  logic signed [DKW-1:0] dk_p [3];
  logic signed [DRW-1:0] dr_p [3];
  logic signed [EEW-1:0] ee_p;

  sfj_mul #(.WA(32), .WB(EXW), .SHIFT(F)) u_se (
    .clk(clk), .en(en), .a({1'b0, stiff_w}), .b(ext_w), .p(se_p)
  );
  sfj_mul #(.WA(EXW), .WB(EXW), .SHIFT(F)) u_ee (
    .clk(clk), .en(en), .a(ext_w), .b(ext_w), .p(ee_p)
  );

  generate
    for (g = 0; g < 3; g++) begin : g_m1
      localparam int OA = (g == 2) ? 1 : 0;
      localparam int OB = (g == 0) ? 1 : 2;
      sfj_mul #(.WA(WW), .WB(WW), .SHIFT(F)) u_wwd (
        .clk(clk), .en(en), .a(w_w[g]), .b(w_w[g]), .p(ww_d[g])
      );
      sfj_mul #(.WA(WW), .WB(WW), .SHIFT(F)) u_wwo (
        .clk(clk), .en(en), .a(w_w[OA]), .b(w_w[OB]), .p(ww_o[g])
      );
      sfj_mul #(.WA(EXW), .WB(WW), .SHIFT(F)) u_dk (
        .clk(clk), .en(en), .a(ext_w), .b(w_w[g]), .p(dk_p[g])
      );
      sfj_mul #(.WA(32), .WB(WW), .SHIFT(F)) u_dr (
        .clk(clk), .en(en), .a({1'b0, stiff_w}), .b(w_w[g]), .p(dr_p[g])
      );
    end
  endgenerate

  logic [DAW-1:0] da_q;
  logic [PARM_W-1:0] stiff_a, rest_a;
  logic signed [EXW-1:0] ext_a;
  logic signed [SW-1:0] s_a;
  logic degen_a;
  logic signed [WW-1:0] w_a [3];

  sfj_dly #(.W(DAW), .DEPTH(LM)) u_da (
    .clk(clk), .en(en),
    .d({stiff_w, rest_w, ext_w, s_w, degen_w, w_w[0], w_w[1], w_w[2]}),
    .q(da_q)
  );
  assign {stiff_a, rest_a, ext_a, s_a, degen_a, w_a[0], w_a[1], w_a[2]} = da_q;

  // Second multiply round.
  logic signed [FW-1:0]  frc_p [3];
  logic signed [RWW-1:0] rwd_p [3];
  logic signed [RWW-1:0] rwo_p [3];
  logic signed [ENW-1:0] en_p;

  sfj_mul #(.WA(32), .WB(EEW), .SHIFT(F)) u_en (
    .clk(clk), .en(en), .a({1'b0, stiff_a}), .b(ee_p), .p(en_p)
  );

  generate
    for (g = 0; g < 3; g++) begin : g_m2
      sfj_mul #(.WA(SEW), .WB(WW), .SHIFT(F)) u_frc (
        .clk(clk), .en(en), .a(se_p), .b(w_a[g]), .p(frc_p[g])
      );
      sfj_mul #(.WA(32), .WB(WWW), .SHIFT(F)) u_rwd (
        .clk(clk), .en(en), .a({1'b0, rest_a}), .b(ww_d[g]), .p(rwd_p[g])
      );
      sfj_mul #(.WA(32), .WB(WWW), .SHIFT(F)) u_rwo (
        .clk(clk), .en(en), .a({1'b0, rest_a}), .b(ww_o[g]), .p(rwo_p[g])
      );
    end
  endgenerate

  logic [DBW-1:0] db_q;
  logic signed [EXW-1:0] ext_b;
  logic signed [SW-1:0] s_b;
  logic degen_b;
  logic signed [DKW-1:0] dk_b [3];
  logic signed [DRW-1:0] dr_b [3];

  sfj_dly #(.W(DBW), .DEPTH(LM)) u_db (
    .clk(clk), .en(en),
    .d({ext_a, s_a, degen_a, dk_p[0], dk_p[1], dk_p[2], dr_p[0], dr_p[1], dr_p[2]}),
    .q(db_q)
  );
  assign {ext_b, s_b, degen_b, dk_b[0], dk_b[1], dk_b[2], dr_b[0], dr_b[1], dr_b[2]} = db_q;

  // Diagonal term: extension plus rest length times the squared component.
  logic signed [XW-1:0]  x_r [3];
  logic signed [RWW-1:0] ro_r [3];
  logic signed [FW-1:0]  frc_r [3];
  logic signed [DKW-1:0] dk_r [3];
  logic signed [DRW-1:0] dr_r [3];
  logic signed [SW-1:0]  s_r;
  logic signed [ENW-1:0] en_r;
  logic degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x_r[i]   <= XW'(ext_b) + XW'(rwd_p[i]);
        ro_r[i]  <= rwo_p[i];
        frc_r[i] <= frc_p[i];
        dk_r[i]  <= dk_b[i];
        dr_r[i]  <= dr_b[i];
      end
      s_r     <= s_b;
      en_r    <= en_p;
      degen_r <= degen_b;
    end
  end

  // Third multiply round.
  logic signed [DGW-1:0] dg_e [3];
  logic signed [OFW-1:0] of_e [3];

  generate
    for (g = 0; g < 3; g++) begin : g_m3
      sfj_mul #(.WA(SW), .WB(XW), .SHIFT(F)) u_dg (
        .clk(clk), .en(en), .a(s_r), .b(x_r[g]), .p(dg_e[g])
      );
      sfj_mul #(.WA(SW), .WB(RWW), .SHIFT(F)) u_of (
        .clk(clk), .en(en), .a(s_r), .b(ro_r[g]), .p(of_e[g])
      );
    end
  endgenerate

  logic [DCW-1:0] dc_q;
  logic signed [FW-1:0]  frc_e [3];
  logic signed [ENW-1:0] en_e;
  logic signed [DKW-1:0] dk_e [3];
  logic signed [DRW-1:0] dr_e [3];
  logic degen_e;

  sfj_dly #(.W(DCW), .DEPTH(LM)) u_dc (
    .clk(clk), .en(en),
    .d({frc_r[0], frc_r[1], frc_r[2], en_r, dk_r[0], dk_r[1], dk_r[2],
        dr_r[0], dr_r[1], dr_r[2], degen_r}),
    .q(dc_q)
  );
  assign {frc_e[0], frc_e[1], frc_e[2], en_e, dk_e[0], dk_e[1], dk_e[2],
          dr_e[0], dr_e[1], dr_e[2], degen_e} = dc_q;

  // Result bank: saturated words of one spring, sent out one group a cycle while m_tready is high.
  logic [VAL_W-1:0] bank [N_GROUPS][3];
  logic degen_q;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        bank[GRP_FORCE][i]  <= sat32(SAT_W'(frc_e[i]), 1'b1, degen_e);
        bank[GRP_DIAG][i]   <= sat32(SAT_W'(dg_e[i]), 1'b1, degen_e);
        bank[GRP_OFF][i]    <= sat32(SAT_W'(of_e[i]), 1'b1, degen_e);
        bank[GRP_DSTIFF][i] <= sat32(SAT_W'(dk_e[i]), 1'b1, degen_e);
        bank[GRP_DREST][i]  <= sat32(SAT_W'(dr_e[i]), 1'b0, degen_e);
      end
      bank[GRP_ENERGY][0] <= sat32(SAT_W'(en_e >>> 1), 1'b0, degen_e);
      bank[GRP_ENERGY][1] <= '0;
      bank[GRP_ENERGY][2] <= '0;
      degen_q <= degen_e;
    end
  end

  // Group counter of the word on the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= GRP_FORCE;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= GRP_FORCE;
    end else if (busy && m_tready) begin
      if (cnt == GRP_ENERGY) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = M_TDATA_W'({bank[cnt][2], bank[cnt][1], bank[cnt][0], cnt});
  assign m_tlast  = (cnt == GRP_ENERGY);
  assign m_tuser  = degen_q;

  // The group counter never runs past the energy word.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= GRP_ENERGY))
    else $error("group counter out of range");

  // A new spring is loaded only once the previous one has fully left.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || (m_tready && cnt == GRP_ENERGY)))
    else $error("result bank overwritten");

  // A finished spring waiting at the pipeline end is not dropped.
  a_hold_end: assert property (@(posedge clk) disable iff (rst)
    (vld[TE] && !load) |=> vld[TE])
    else $error("pipeline result lost while stalled");

  // A stalled output word keeps its group.
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (busy && !m_tready) |=> (busy && $stable(cnt)))
    else $error("output group changed while stalled");

endmodule

`default_nettype wire

### sv/sfj_dly.sv
// ----------------------------------------------------------------------------
// Spring force and Jacobian delay line
// Shift register that carries side data alongside the arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

module sfj_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  // Every tap moves one place when the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

`default_nettype wire

### sv/sfj_mul.sv
// ----------------------------------------------------------------------------
// Spring force and Jacobian multiplier
// Signed fixed-point product in five stages: magnitudes, 32x32 partial
// products, two adds, then the fraction shift and the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module sfj_mul import sfj_pkg::*; #(
  parameter int WA    = 32,
  parameter int WB    = 32,
  parameter int SHIFT = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [WA-1:0]       a,
  input  logic signed [WB-1:0]       b,
  output logic signed [WA+WB-SHIFT:0] p
);

  localparam int WO = WA + WB - SHIFT + 1;

  logic signed [WA:0] ax;
  logic signed [WB:0] bx;
  logic [WA:0] am;
  logic [WB:0] bm;
  logic [63:0] ma1, mb1;
  logic [63:0] pp00, pp01, pp10, pp11;
  logic [127:0] lo3;
  logic [64:0] mid3;
  logic [127:0] prod4;
  logic [127:0] shf;
  logic signed [WO-1:0] pv;
  logic neg1, neg2, neg3, neg4;

  // Magnitudes; the widened copy keeps the most negative value exact.
  assign ax = a;
  assign bx = b;
  assign am = ax[WA] ? -ax : ax;
  assign bm = bx[WB] ? -bx : bx;

  always_ff @(posedge clk) begin
    if (en) begin
      ma1  <= 64'(am[WA-1:0]);
      mb1  <= 64'(bm[WB-1:0]);
      neg1 <= a[WA-1] ^ b[WB-1];
    end
  end

  // Four 32x32 partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= ma1[31:0] * mb1[31:0];
      pp01 <= ma1[31:0] * mb1[63:32];
      pp10 <= ma1[63:32] * mb1[31:0];
      pp11 <= ma1[63:32] * mb1[63:32];
      neg2 <= neg1;
    end
  end

  // Outer terms do not overlap; the middle terms are summed.
  always_ff @(posedge clk) begin
    if (en) begin
      lo3  <= {pp11, pp00};
      mid3 <= 65'(pp01) + 65'(pp10);
      neg3 <= neg2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod4 <= lo3 + (128'(mid3) << 32);
      neg4  <= neg3;
    end
  end

  // Shifting the magnitude truncates toward zero.
  assign shf = prod4 >> SHIFT;
  assign pv  = WO'(shf);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg4 ? -pv : pv;
    end
  end

endmodule

`default_nettype wire

### sv/sfj_sqrt.sv
// ----------------------------------------------------------------------------
// Spring force and Jacobian square root
// Floor square root of the squared length, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfj_sqrt import sfj_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_W-1:0]  rad,
  output logic [LEN_W-1:0] root
);

  localparam int REM_W = LEN_W + 2;

  logic [SQ_W-1:0]  rad_r  [LEN_W];
  logic [LEN_W-1:0] root_r [LEN_W];
  logic [REM_W-1:0] rem_r  [LEN_W];

  genvar g;
  generate
    for (g = 0; g < LEN_W; g++) begin : g_step
      logic [SQ_W-1:0]  rad_p;
      logic [LEN_W-1:0] root_p;
      logic [REM_W-1:0] rem_p;
      logic [REM_W+1:0] rem2, trial, diff;
      logic ge;

      if (g == 0) begin : g_first
        assign rad_p  = rad;
        assign root_p = '0;
        assign rem_p  = '0;
      end else begin : g_next
        assign rad_p  = rad_r[g-1];
        assign root_p = root_r[g-1];
        assign rem_p  = rem_r[g-1];
      end

      // Bring down the next bit pair and try the trial subtrahend.
      assign rem2  = {rem_p, rad_p[SQ_W-1 -: 2]};
      assign trial = (REM_W+2)'({root_p, 2'b01});
      assign diff  = rem2 - trial;
      assign ge    = (rem2 >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[g]  <= rad_p << 2;
          root_r[g] <= {root_p[LEN_W-2:0], ge};
          rem_r[g]  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
        end
      end
    end
  endgenerate

  assign root = root_r[LEN_W-1];

endmodule

`default_nettype wire

### sv/sfj_div.sv
// ----------------------------------------------------------------------------
// Spring force and Jacobian divider
// Restoring unsigned division of a numerator by the spring length, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfj_div #(
  parameter int NW = 49,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] den_r [NW];

  genvar g;
  generate
    for (g = 0; g < NW; g++) begin : g_step
      logic [NW-1:0] num_p, quo_p;
      logic [DW-1:0] rem_p, den_p;
      logic [DW:0] rem2, diff;
      logic ge;

      if (g == 0) begin : g_first
        assign num_p = num;
        assign quo_p = '0;
        assign rem_p = '0;
        assign den_p = den;
      end else begin : g_next
        assign num_p = num_r[g-1];
        assign quo_p = quo_r[g-1];
        assign rem_p = rem_r[g-1];
        assign den_p = den_r[g-1];
      end

      // Shift in the next numerator bit and subtract the divisor if it fits.
      assign rem2 = {rem_p, num_p[NW-1]};
      assign ge   = (rem2 >= {1'b0, den_p});
      assign diff = rem2 - {1'b0, den_p};

      always_ff @(posedge clk) begin
        if (en) begin
          num_r[g] <= num_p << 1;
          quo_r[g] <= {quo_p[NW-2:0], ge};
          rem_r[g] <= ge ? diff[DW-1:0] : rem2[DW-1:0];
          den_r[g] <= den_p;
        end
      end
    end
  endgenerate

  assign quo = quo_r[NW-1];

endmodule

`default_nettype wire
